// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the per-source forwarding buffer.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/psfb_pkg.sv -----
// Package of the per-source forwarding buffer: codes, defaults, command types.
// Depends on nothing; used by the controller, the datapath and the top level.
package psfb_pkg;

  localparam int NUM_SOURCES_DEF      = 8;
  localparam int SLOTS_PER_SOURCE_DEF = 4;

  localparam logic [31:0] DEADLINE_RESET = 32'd10000;

  localparam logic [1:0] KIND_ENQ    = 2'd0;
  localparam logic [1:0] KIND_DEQ    = 2'd1;
  localparam logic [1:0] KIND_EXPIRE = 2'd2;
  localparam logic [1:0] KIND_PROBE  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NACK  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic src_ev;
    logic src_apply;
    logic slot_ev;
    logic deq_rd;
    logic deq_apply;
    logic finish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [1:0] kind;
    logic       src_last;
    logic       slot_last;
    logic       out_free;
  } sts_t;

  // One result item.
  typedef struct packed {
    logic [1:0]  status;
    logic        accept_ok;
    logic [63:0] out_source_id;
    logic [15:0] out_handle;
    logic [15:0] out_length;
    logic [5:0]  expired_count;
    logic [5:0]  total_queued;
    logic [31:0] dropped_full_total;
    logic [31:0] nacks_total;
    logic [31:0] queued_total_count;
    logic [31:0] forwarded_total;
    logic [31:0] dropped_deadline_total;
  } rsp_t;

  // True when time a lies before time b on the wrapping 32-bit clock.
  function automatic logic is_older(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

endpackage

// ----- rtl/psfb_req_if.sv -----
// Request channel of the per-source forwarding buffer: valid, ready, payload.
// Depends on nothing.
interface psfb_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [63:0] source_id;
  logic [15:0] packet_handle;
  logic [15:0] packet_length;
  logic [31:0] now_ms;

  modport source (output valid, kind, source_id, packet_handle, packet_length, now_ms,
                  input ready);
  modport sink (input valid, kind, source_id, packet_handle, packet_length, now_ms,
                output ready);
endinterface

// ----- rtl/psfb_rsp_if.sv -----
// Result channel of the per-source forwarding buffer: valid, ready, payload.
// Depends on nothing.
interface psfb_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        accept_ok;
  logic [63:0] out_source_id;
  logic [15:0] out_handle;
  logic [15:0] out_length;
  logic [5:0]  expired_count;
  logic [5:0]  total_queued;
  logic [31:0] dropped_full_total;
  logic [31:0] nacks_total;
  logic [31:0] queued_total_count;
  logic [31:0] forwarded_total;
  logic [31:0] dropped_deadline_total;

  modport source (output valid, status, accept_ok, out_source_id, out_handle, out_length,
                  expired_count, total_queued, dropped_full_total, nacks_total,
                  queued_total_count, forwarded_total, dropped_deadline_total,
                  input ready);
  modport sink (input valid, status, accept_ok, out_source_id, out_handle, out_length,
                expired_count, total_queued, dropped_full_total, nacks_total,
                queued_total_count, forwarded_total, dropped_deadline_total,
                output ready);
endinterface

// ----- rtl/psfb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module psfb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/psfb_ctrl.sv -----
// Controller of the per-source forwarding buffer: sequences the source and slot scans.
// Depends on psfb_pkg.
module psfb_ctrl import psfb_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);
  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_SRC_RD    = 4'd1;
  localparam logic [3:0] S_SRC_EV    = 4'd2;
  localparam logic [3:0] S_SRC_APPLY = 4'd3;
  localparam logic [3:0] S_SLOT_RD   = 4'd4;
  localparam logic [3:0] S_SLOT_EV   = 4'd5;
  localparam logic [3:0] S_DEQ_RD    = 4'd6;
  localparam logic [3:0] S_DEQ_APPLY = 4'd7;
  localparam logic [3:0] S_FINISH    = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_SRC_RD;
        end
      end
      S_SRC_RD: begin
        // The kind is known only once the item is loaded.
        if (sts.kind == KIND_DEQ || sts.kind == KIND_EXPIRE) begin
          state_next = S_SLOT_EV;
        end else begin
          state_next = S_SRC_EV;
        end
      end
      S_SRC_EV: begin
        cmd.src_ev = 1'b1;
        state_next = sts.src_last ? S_SRC_APPLY : S_SRC_RD;
      end
      S_SRC_APPLY: begin
        cmd.src_apply = 1'b1;
        state_next = S_FINISH;
      end
      S_SLOT_RD: begin
        state_next = S_SLOT_EV;
      end
      S_SLOT_EV: begin
        cmd.slot_ev = 1'b1;
        if (!sts.slot_last) begin
          state_next = S_SLOT_RD;
        end else if (sts.kind == KIND_DEQ) begin
          state_next = S_DEQ_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_DEQ_RD: begin
        cmd.deq_rd = 1'b1;
        state_next = S_DEQ_APPLY;
      end
      S_DEQ_APPLY: begin
        cmd.deq_apply = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule

// ----- rtl/psfb_datapath.sv -----
// Datapath of the per-source forwarding buffer: tables, scan registers, counters, result.
// Depends on psfb_pkg and psfb_ram.
module psfb_datapath import psfb_pkg::*; #(
  parameter int NUM_SOURCES      = NUM_SOURCES_DEF,
  parameter int SLOTS_PER_SOURCE = SLOTS_PER_SOURCE_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  input  logic [1:0]  in_kind,
  input  logic [63:0] in_source_id,
  input  logic [15:0] in_handle,
  input  logic [15:0] in_length,
  input  logic [31:0] in_now,
  output logic        out_valid,
  input  logic        out_ready,
  output rsp_t        res
);
  localparam int TOTAL = NUM_SOURCES * SLOTS_PER_SOURCE;
  localparam int SW    = NUM_SOURCES > 1 ? $clog2(NUM_SOURCES) : 1;
  localparam int KW    = TOTAL > 1 ? $clog2(TOTAL) : 1;
  localparam int JW    = SLOTS_PER_SOURCE > 1 ? $clog2(SLOTS_PER_SOURCE) : 1;
  localparam int CW    = $clog2(SLOTS_PER_SOURCE + 1);
  localparam int TW    = $clog2(TOTAL + 1);

  // Captured item.
  logic [1:0]  kind;
  logic [63:0] sid;
  logic [15:0] handle;
  logic [15:0] length;
  logic [31:0] now;
  logic [31:0] deadline;

  // Scan position.
  logic [SW-1:0] s_idx;
  logic [JW-1:0] j_idx;
  logic [KW-1:0] k_idx;

  // Source scan findings.
  logic          match_found, free_found, old_found;
  logic [SW-1:0] match_s, free_s, old_s;
  logic [31:0]   old_la;

  // Slot scan findings.
  logic          best_found;
  logic [KW-1:0] best_k;
  logic [SW-1:0] best_s;
  logic [31:0]   best_t;
  logic [15:0]   best_h, best_l;

  // Tables kept in flip-flops.
  logic [NUM_SOURCES-1:0] src_valid;
  logic [CW-1:0]          src_count [NUM_SOURCES];
  logic [TOTAL-1:0]       slot_valid;
  logic [TW-1:0]          total;
  logic [31:0]            st_drop_full, st_nacks, st_queued, st_fwd, st_dl;

  // Result under construction.
  logic [1:0]    r_status;
  logic          r_accept;
  logic [63:0]   r_sid;
  logic [15:0]   r_handle, r_length;
  logic [TW-1:0] r_expired;

  // RAM ports.
  logic          src_we;
  logic [SW-1:0] src_waddr, src_raddr;
  logic [95:0]   src_wdata, src_rdata;
  logic          slot_we;
  logic [KW-1:0] slot_waddr;
  logic [63:0]   slot_wdata, slot_rdata;

  logic [63:0] rd_key;
  logic [31:0] rd_la, rd_time;
  logic [15:0] rd_handle, rd_length;

  assign rd_key    = src_rdata[95:32];
  assign rd_la     = src_rdata[31:0];
  assign rd_handle = slot_rdata[63:48];
  assign rd_length = slot_rdata[47:32];
  assign rd_time   = slot_rdata[31:0];

  // Enqueue decision once the source scan is done.
  logic [SW-1:0]         sel_s;
  logic                  new_grp, evict, at_limit;
  logic [CW-1:0]         cnt_sel, cnt_eff;
  logic [KW-1:0]         sel_base, wr_k;
  logic [SLOTS_PER_SOURCE-1:0] grp_bits;
  logic [JW-1:0]         free_j;

  always_comb begin
    sel_s    = match_found ? match_s : (free_found ? free_s : old_s);
    new_grp  = !match_found;
    evict    = !match_found && !free_found;
    cnt_sel  = src_count[sel_s];
    cnt_eff  = new_grp ? '0 : cnt_sel;
    at_limit = cnt_eff >= CW'(SLOTS_PER_SOURCE);
    sel_base = KW'(KW'(sel_s) * KW'(SLOTS_PER_SOURCE));
    for (int j = 0; j < SLOTS_PER_SOURCE; j++) begin
      grp_bits[j] = new_grp ? 1'b0 : slot_valid[KW'(sel_base + KW'(j))];
    end
    free_j = '0;
    for (int j = SLOTS_PER_SOURCE - 1; j >= 0; j--) begin
      if (!grp_bits[j]) begin
        free_j = JW'(j);
      end
    end
    wr_k = KW'(sel_base + KW'(free_j));
  end

  // Slot scan evaluation.
  logic          exp_hit, deq_better;
  logic [31:0]   age;
  logic [CW-1:0] cnt_s, cnt_after, cnt_best;

  always_comb begin
    age        = now - rd_time;
    exp_hit    = slot_valid[k_idx] && (age > deadline);
    deq_better = slot_valid[k_idx] && (!best_found || is_older(rd_time, best_t));
    cnt_s      = src_count[s_idx];
    cnt_after  = cnt_s - CW'(exp_hit);
    cnt_best   = src_count[best_s];
  end

  assign src_raddr  = cmd.deq_rd ? best_s : s_idx;
  assign src_we     = (cmd.src_apply && kind == KIND_ENQ && !at_limit) ||
                      (cmd.deq_apply && best_found);
  assign src_waddr  = cmd.deq_apply ? best_s : sel_s;
  assign src_wdata  = cmd.deq_apply ? {rd_key, best_t} : {sid, now};
  assign slot_we    = cmd.src_apply && kind == KIND_ENQ && !at_limit;
  assign slot_waddr = wr_k;
  assign slot_wdata = {handle, length, now};

  psfb_ram #(.WIDTH(96), .DEPTH(NUM_SOURCES)) u_src_ram (
    .clk   (clk),
    .we    (src_we),
    .waddr (src_waddr),
    .wdata (src_wdata),
    .raddr (src_raddr),
    .rdata (src_rdata)
  );

  psfb_ram #(.WIDTH(64), .DEPTH(TOTAL)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (slot_wdata),
    .raddr (k_idx),
    .rdata (slot_rdata)
  );

  assign sts.kind      = kind;
  assign sts.src_last  = s_idx == SW'(NUM_SOURCES - 1);
  assign sts.slot_last = k_idx == KW'(TOTAL - 1);
  assign sts.out_free  = !out_valid || out_ready;

  // State with a defined reset value.
  always_ff @(posedge clk) begin
    if (rst) begin
      deadline     <= DEADLINE_RESET;
      src_valid    <= '0;
      slot_valid   <= '0;
      total        <= '0;
      st_drop_full <= '0;
      st_nacks     <= '0;
      st_queued    <= '0;
      st_fwd       <= '0;
      st_dl        <= '0;
      out_valid    <= 1'b0;
      for (int s = 0; s < NUM_SOURCES; s++) begin
        src_count[s] <= '0;
      end
    end else begin
      if (cfg_we) begin
        deadline <= cfg_wdata;
      end
      if (cmd.src_apply && kind == KIND_ENQ) begin
        if (at_limit) begin
          st_drop_full <= st_drop_full + 32'd1;
          st_nacks     <= st_nacks + 32'd1;
        end else begin
          if (new_grp) begin
            for (int j = 0; j < SLOTS_PER_SOURCE; j++) begin
              slot_valid[KW'(sel_base + KW'(j))] <= 1'b0;
            end
          end
          slot_valid[wr_k]   <= 1'b1;
          src_count[sel_s]   <= cnt_eff + CW'(1);
          src_valid[sel_s]   <= 1'b1;
          st_queued          <= st_queued + 32'd1;
          total              <= total - (evict ? TW'(cnt_sel) : '0) + TW'(1);
          st_drop_full       <= st_drop_full + (evict ? 32'(cnt_sel) : 32'd0);
        end
      end
      if (cmd.slot_ev && kind == KIND_EXPIRE) begin
        if (exp_hit) begin
          slot_valid[k_idx] <= 1'b0;
          src_count[s_idx]  <= cnt_after;
          st_dl             <= st_dl + 32'd1;
          total             <= total - TW'(1);
        end
        // A source left empty at the end of its group is released.
        if (j_idx == JW'(SLOTS_PER_SOURCE - 1) && cnt_after == '0) begin
          src_valid[s_idx] <= 1'b0;
        end
      end
      if (cmd.deq_apply && best_found) begin
        slot_valid[best_k] <= 1'b0;
        src_count[best_s]  <= cnt_best - CW'(1);
        if (cnt_best == CW'(1)) begin
          src_valid[best_s] <= 1'b0;
        end
        st_fwd <= st_fwd + 32'd1;
        total  <= total - TW'(1);
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Scan registers and payload.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind        <= in_kind;
      sid         <= in_source_id;
      handle      <= in_handle;
      length      <= in_length;
      now         <= in_now;
      s_idx       <= '0;
      j_idx       <= '0;
      k_idx       <= '0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      old_found   <= 1'b0;
      best_found  <= 1'b0;
      r_status    <= ST_OK;
      r_accept    <= 1'b0;
      r_sid       <= '0;
      r_handle    <= '0;
      r_length    <= '0;
      r_expired   <= '0;
    end
    if (cmd.src_ev) begin
      if (src_valid[s_idx] && rd_key == sid && !match_found) begin
        match_found <= 1'b1;
        match_s     <= s_idx;
      end
      if (!src_valid[s_idx] && !free_found) begin
        free_found <= 1'b1;
        free_s     <= s_idx;
      end
      if (src_valid[s_idx] && !free_found && (!old_found || is_older(rd_la, old_la))) begin
        old_found <= 1'b1;
        old_s     <= s_idx;
        old_la    <= rd_la;
      end
      s_idx <= SW'(s_idx + SW'(1));
    end
    if (cmd.src_apply) begin
      if (kind == KIND_ENQ && at_limit) begin
        r_status <= ST_NACK;
      end
      if (kind == KIND_PROBE) begin
        r_accept <= !match_found || (src_count[match_s] < CW'(SLOTS_PER_SOURCE));
      end
    end
    if (cmd.slot_ev) begin
      if (kind == KIND_DEQ && deq_better) begin
        best_found <= 1'b1;
        best_k     <= k_idx;
        best_s     <= s_idx;
        best_t     <= rd_time;
        best_h     <= rd_handle;
        best_l     <= rd_length;
      end
      if (kind == KIND_EXPIRE && exp_hit) begin
        r_expired <= r_expired + TW'(1);
      end
      k_idx <= KW'(k_idx + KW'(1));
      if (j_idx == JW'(SLOTS_PER_SOURCE - 1)) begin
        j_idx <= '0;
        s_idx <= SW'(s_idx + SW'(1));
      end else begin
        j_idx <= JW'(j_idx + JW'(1));
      end
    end
    if (cmd.deq_apply) begin
      if (best_found) begin
        r_sid    <= rd_key;
        r_handle <= best_h;
        r_length <= best_l;
      end else begin
        r_status <= ST_EMPTY;
      end
    end
    if (cmd.finish) begin
      res.status                 <= r_status;
      res.accept_ok              <= r_accept;
      res.out_source_id          <= r_sid;
      res.out_handle             <= r_handle;
      res.out_length             <= r_length;
      res.expired_count          <= 6'(r_expired);
      res.total_queued           <= 6'(total);
      res.dropped_full_total     <= st_drop_full;
      res.nacks_total            <= st_nacks;
      res.queued_total_count     <= st_queued;
      res.forwarded_total        <= st_fwd;
      res.dropped_deadline_total <= st_dl;
    end
  end
endmodule

// ----- rtl/per_source_forwarding_buffer.sv -----
// Per-source forwarding buffer: a relay buffer of packet descriptors grouped by source id.
// Each request is handled one at a time. Enqueue and probe scan the source table;
// dequeue scans every slot and then fetches the source key; expire scans every slot.
// Each scan step is a registered read of the source or slot RAM followed by the compare
// and update. A request is taken while the previous result still waits in the output
// register; the next result is written only once that register is free. The deadline
// register may be written only while the block is idle. After reset the buffer is empty
// and needs no clearing pass.
// Depends on psfb_pkg, the channel interfaces, psfb_ctrl, psfb_datapath and assert_macros.svh.
`include "assert_macros.svh"

module per_source_forwarding_buffer import psfb_pkg::*; #(
  parameter int NUM_SOURCES      = NUM_SOURCES_DEF,
  parameter int SLOTS_PER_SOURCE = SLOTS_PER_SOURCE_DEF
) (
  input logic        clk,
  input logic        rst,
  psfb_req_if.sink   req,
  psfb_rsp_if.source rsp,
  input logic        cfg_we,
  input logic [31:0] cfg_wdata
);
  cmd_t cmd;
  sts_t sts;
  rsp_t res;

  // The controller owns the sequence: load, scan, apply, then hand the result over.
  psfb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (req.valid),
    .in_ready (req.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // The datapath holds all tables, the statistics counters and the result register.
  psfb_datapath #(
    .NUM_SOURCES      (NUM_SOURCES),
    .SLOTS_PER_SOURCE (SLOTS_PER_SOURCE)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_kind      (req.kind),
    .in_source_id (req.source_id),
    .in_handle    (req.packet_handle),
    .in_length    (req.packet_length),
    .in_now       (req.now_ms),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .res          (res)
  );

  assign rsp.status                 = res.status;
  assign rsp.accept_ok              = res.accept_ok;
  assign rsp.out_source_id          = res.out_source_id;
  assign rsp.out_handle             = res.out_handle;
  assign rsp.out_length             = res.out_length;
  assign rsp.expired_count          = res.expired_count;
  assign rsp.total_queued           = res.total_queued;
  assign rsp.dropped_full_total     = res.dropped_full_total;
  assign rsp.nacks_total            = res.nacks_total;
  assign rsp.queued_total_count     = res.queued_total_count;
  assign rsp.forwarded_total        = res.forwarded_total;
  assign rsp.dropped_deadline_total = res.dropped_deadline_total;

  // A taken request keeps the block busy for at least the next cycle.
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, req.valid && req.ready, !req.ready)
  // Only a dequeue of an empty buffer reports empty, so nothing can be queued then.
  `ASSERT_IMPLIES(a_empty_zero, clk, rst, rsp.valid && rsp.status == ST_EMPTY, rsp.total_queued == 6'd0)
  // Expiry never reports a rejection or an empty buffer.
  `ASSERT_IMPLIES(a_expire_ok, clk, rst, rsp.valid && rsp.expired_count != 6'd0, rsp.status == ST_OK)
endmodule
